### hdl/lzw_variable_width_decoder_core_assert.svh
// assertion macros for the lzw decoder
`ifndef LZW_VARIABLE_WIDTH_DECODER_CORE_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_CORE_ASSERT_SVH
// implication checked on every clock, held off during reset
`define LZW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lzw check failed");
// next-cycle implication
`define LZW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lzw check failed");
`endif

### hdl/lzwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lzwd_pkg;
    localparam int MaxWidth = 12;
    localparam int BufBits  = 20;
    localparam int StackDepth = 4096;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_PULL  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_PIXEL    = 3'd0,
        ST_NEED     = 3'd1,
        ST_CLEAR    = 3'd2,
        ST_END      = 3'd3,
        ST_BAD      = 3'd4,
        ST_ACCEPTED = 3'd5,
        ST_REFUSED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOOKUP,
        S_WALK,
        S_POP,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    start;
        logic    push;
        logic    decide;
        logic    lookup;
        logic    walk;
        logic    pop;
        logic    set_status;
        status_t status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    stack_empty;
        logic    image_done;
        logic    push_ok;
        logic    enough_bits;
        logic    is_clear;
        logic    is_end;
        logic    is_known;
        logic    is_kwkwk;
        logic    walk_done;
    } stat_t;
endpackage
`default_nettype wire

### hdl/lzwd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lzwd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_func,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire lzwd_pkg::stat_t  stat,
    output lzwd_pkg::cmd_t        cmd
);
    import lzwd_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = (func_t'(s_func) == FUNC_PULL) ? S_DECIDE : S_IDLE;
            S_DECIDE: begin
                if (!stat.stack_empty || stat.image_done || !stat.enough_bits) state_next = S_OUT;
                else state_next = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (stat.is_clear || stat.is_end) state_next = S_IDLE;
                else if (stat.is_known || stat.is_kwkwk) state_next = S_WALK;
                else state_next = S_IDLE;
            end
            S_WALK:   if (stat.walk_done) state_next = S_POP;
            S_POP:    state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.status = ST_REFUSED;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: if (accept) begin
                unique case (func_t'(s_func))
                    FUNC_START: begin
                        cmd.start = 1'b1; cmd.set_status = 1'b1; cmd.status = ST_NEED;
                        m_valid_next = 1'b1;
                    end
                    FUNC_PUSH: begin
                        cmd.push = 1'b1; cmd.set_status = 1'b1;
                        cmd.status = stat.push_ok ? ST_ACCEPTED : ST_REFUSED;
                        m_valid_next = 1'b1;
                    end
                    FUNC_PULL: ;
                    FUNC_NONE: begin
                        cmd.set_status = 1'b1; cmd.status = ST_REFUSED;
                        m_valid_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                if (!stat.stack_empty) begin
                    cmd.pop = 1'b1; cmd.status = ST_PIXEL;
                end else if (stat.image_done) cmd.status = ST_END;
                else if (!stat.enough_bits) cmd.status = ST_NEED;
                else cmd.set_status = 1'b0;
                cmd.decide = stat.stack_empty && !stat.image_done && stat.enough_bits;
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                cmd.set_status = 1'b1;
                if (stat.is_clear) cmd.status = ST_CLEAR;
                else if (stat.is_end) cmd.status = ST_END;
                else if (stat.is_known || stat.is_kwkwk) cmd.set_status = 1'b0;
                else cmd.status = ST_BAD;
                if (cmd.set_status) m_valid_next = 1'b1;
            end
            S_WALK: cmd.walk = 1'b1;
            S_POP: begin
                cmd.pop = 1'b1; cmd.set_status = 1'b1; cmd.status = ST_PIXEL;
            end
            S_OUT: m_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `include "lzw_variable_width_decoder_core_assert.svh"
    `LZW_ASSERT_IMP(a_busy_not_ready, state_reg != S_IDLE, !s_ready)
    `LZW_ASSERT_IMP(a_out_holds_ready, m_valid_reg, !s_ready)
    `LZW_ASSERT_NEXT(a_pop_then_out, state_reg == S_POP, state_reg == S_OUT)
endmodule
`default_nettype wire

### hdl/lzwd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lzwd_datapath #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [3:0]      min_code_size,
    input  wire logic [7:0]      s_data_byte,
    input  wire lzwd_pkg::cmd_t  cmd,
    output lzwd_pkg::stat_t      stat,
    output logic [7:0]           m_pixel,
    output logic [2:0]           m_status
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [11:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]  suffix_mem [TABLE_ENTRIES];
    logic [7:0]  first_mem  [TABLE_ENTRIES];
    logic [7:0]  stack_mem  [StackDepth];

    logic [3:0]  size_reg;
    logic [12:0] stack_cnt_reg;
    logic [19:0] buf_reg;
    logic [4:0]  bcnt_reg;
    logic [3:0]  width_reg;
    logic [12:0] free_reg;
    logic [11:0] prev_reg;
    logic        prev_valid_reg;
    logic        done_reg;
    logic [11:0] code_reg;
    logic [12:0] walk_reg;
    logic        walk_done_reg;
    logic [2:0]  status_reg;
    logic [7:0]  pop_data;
    logic [7:0]  pop_data_hold;

    logic [12:0] clr, roots;
    logic [11:0] mask, code_now;
    logic [3:0]  size_clamp;
    logic        table_open;
    logic        walk_in_table;
    logic [AW-1:0] waddr;

    assign clr   = 13'd1 << size_reg;
    assign roots = clr + 13'd2;
    assign mask  = 12'((13'd1 << width_reg) - 13'd1);
    assign code_now = buf_reg[11:0] & mask;
    assign size_clamp = (min_code_size < 4'd2) ? 4'd2 :
                        (min_code_size > 4'd8) ? 4'd8 : min_code_size;
    assign table_open = free_reg < 13'(TABLE_ENTRIES);
    assign walk_in_table = (walk_reg >= roots) && (walk_reg < 13'(TABLE_ENTRIES));
    assign waddr = free_reg[AW-1:0];

    // first pixel of a code: root codes are their own value
    function automatic logic [7:0] root_first(input logic [11:0] c, input logic [12:0] r,
                                              input logic [7:0] tf);
        if ({1'b0, c} < r || {1'b0, c} >= 13'(TABLE_ENTRIES)) return c[7:0];
        return tf;
    endfunction

    always_comb begin
        stat.stack_empty = (stack_cnt_reg == 13'd0);
        stat.image_done  = done_reg;
        stat.push_ok     = !done_reg && (bcnt_reg <= 5'(BufBits - 8));
        stat.enough_bits = {1'b0, bcnt_reg} >= {2'b0, width_reg};
        stat.is_clear    = ({1'b0, code_reg} == clr);
        stat.is_end      = ({1'b0, code_reg} == clr + 13'd1);
        stat.is_known    = ({1'b0, code_reg} < free_reg) && !stat.is_clear && !stat.is_end;
        stat.is_kwkwk    = ({1'b0, code_reg} == free_reg) && prev_valid_reg && table_open;
        stat.walk_done   = walk_done_reg;
    end

    // first_of values read from memory in lookup; registered read
    logic [7:0] first_code_rd, first_prev_rd;
    always_ff @(posedge aclk) begin
        first_code_rd <= first_mem[code_now[AW-1:0]];
        first_prev_rd <= first_mem[prev_reg[AW-1:0]];
    end

    logic [7:0] suf_rd;
    logic [11:0] pre_rd;
    always_ff @(posedge aclk) begin
        suf_rd <= suffix_mem[walk_reg[AW-1:0]];
        pre_rd <= prefix_mem[walk_reg[AW-1:0]];
    end

    logic        do_add;
    logic [7:0]  add_suffix;
    logic [7:0]  fc, fp;
    assign fc = root_first(code_reg, roots, first_code_rd);
    assign fp = root_first(prev_reg, roots, first_prev_rd);
    assign do_add = cmd.lookup && prev_valid_reg && table_open &&
                    (stat.is_known || stat.is_kwkwk);
    assign add_suffix = stat.is_kwkwk ? fp : fc;

    always_ff @(posedge aclk) begin
        if (do_add) begin
            prefix_mem[waddr] <= prev_reg;
            first_mem[waddr]  <= fp;
            suffix_mem[waddr] <= add_suffix;
        end
    end

    // walk step: each link has a table read phase, then a stack push phase
    logic walk_phase_reg;
    logic stack_wr;
    logic [7:0] stack_wd;
    always_comb begin
        stack_wr = 1'b0;
        stack_wd = suf_rd;
        if (cmd.walk && walk_phase_reg && !walk_done_reg && stack_cnt_reg < 13'(StackDepth)) begin
            stack_wr = 1'b1;
            stack_wd = walk_in_table ? suf_rd : walk_reg[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_wr) stack_mem[stack_cnt_reg[11:0]] <= stack_wd;
        pop_data <= stack_mem[12'(stack_cnt_reg - 13'd1)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 4'd8; stack_cnt_reg <= '0; buf_reg <= '0; bcnt_reg <= '0;
            width_reg <= 4'd9; free_reg <= 13'd258; prev_reg <= '0;
            prev_valid_reg <= 1'b0; done_reg <= 1'b0; walk_done_reg <= 1'b0;
            walk_phase_reg <= 1'b0; status_reg <= ST_NEED;
            code_reg <= '0; walk_reg <= '0;
        end else begin
            if (cmd.start) begin
                size_reg <= size_clamp; stack_cnt_reg <= '0; buf_reg <= '0;
                bcnt_reg <= '0; prev_reg <= '0; done_reg <= 1'b0;
                width_reg <= size_clamp + 4'd1;
                free_reg <= (13'd1 << size_clamp) + 13'd2;
                prev_valid_reg <= 1'b0;
            end
            if (cmd.push && stat.push_ok) begin
                buf_reg  <= buf_reg | (20'(s_data_byte) << bcnt_reg);
                bcnt_reg <= bcnt_reg + 5'd8;
            end
            if (cmd.decide) begin
                code_reg <= code_now;
                buf_reg  <= buf_reg >> width_reg;
                bcnt_reg <= bcnt_reg - 5'(width_reg);
            end
            if (cmd.lookup) begin
                walk_reg <= {1'b0, code_reg};
                walk_done_reg <= 1'b0;
                walk_phase_reg <= 1'b0;
                if (stat.is_clear) begin
                    width_reg <= size_reg + 4'd1;
                    free_reg <= roots;
                    prev_valid_reg <= 1'b0;
                end else if (stat.is_end) begin
                    done_reg <= 1'b1;
                end else if (stat.is_known || stat.is_kwkwk) begin
                    prev_reg <= code_reg;
                    prev_valid_reg <= 1'b1;
                    if (do_add) begin
                        free_reg <= free_reg + 13'd1;
                        if (free_reg + 13'd1 == (13'd1 << width_reg) &&
                            free_reg + 13'd1 < 13'(TABLE_ENTRIES) &&
                            width_reg < 4'(MaxWidth))
                            width_reg <= width_reg + 4'd1;
                    end
                end
            end
            if (cmd.walk && !walk_done_reg) begin
                walk_phase_reg <= !walk_phase_reg;
                if (walk_phase_reg) begin
                    if (stack_wr) stack_cnt_reg <= stack_cnt_reg + 13'd1;
                    if (walk_in_table && stack_cnt_reg < 13'(StackDepth)) begin
                        walk_reg <= {1'b0, pre_rd};
                    end else begin
                        walk_done_reg <= 1'b1;
                    end
                end
            end
            if (cmd.pop) stack_cnt_reg <= stack_cnt_reg - 13'd1;
            if (cmd.set_status) status_reg <= cmd.status;
        end
    end

    // popped data arrives in the cycle after the pop command
    logic pop_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) pop_d_reg <= 1'b0;
        else pop_d_reg <= cmd.pop;
    end

    always_ff @(posedge aclk) begin
        if (pop_d_reg) pop_data_hold <= pop_data;
    end

    assign m_status = status_reg;
    assign m_pixel  = (status_reg == ST_PIXEL) ? pop_data_hold : 8'd0;

    `include "lzw_variable_width_decoder_core_assert.svh"
    `LZW_ASSERT_IMP(a_bcnt_range, 1'b1, bcnt_reg <= 5'(BufBits))
    `LZW_ASSERT_IMP(a_width_range, 1'b1, width_reg <= 4'(MaxWidth))
    `LZW_ASSERT_IMP(a_free_range, 1'b1, free_reg <= 13'(TABLE_ENTRIES) || !prev_valid_reg)
endmodule
`default_nettype wire

### hdl/lzw_variable_width_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// LZW raster decoder with variable code width (up to 12 bits). One transaction is in
// flight at a time: the next input is taken only after the result has been taken.
// Paths: a start, push or unused item sets the result straight from idle; a pull that
// pops a waiting pixel, finds too few bits or finds the image ended passes through decide
// and out; a pull whose code is a clear, the end code or a bad code passes through decide
// and lookup; a pull that decodes a new string passes decide, lookup, walk, pop and out,
// walking one link per pixel: each chain step registers the table read before the push.
// min_code_size is latched at each start of image.
module lzw_variable_width_decoder_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pixel,
    output logic [2:0]       m_status
);
    import lzwd_pkg::*;

    logic [3:0] min_size_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) min_size_reg <= 4'd8;
        else if (cfg_wr_en) min_size_reg <= cfg_wr_data;
    end

    lzwd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    lzwd_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .min_code_size(min_size_reg),
        .s_data_byte(s_data_byte), .cmd(cmd), .stat(stat),
        .m_pixel(m_pixel), .m_status(m_status)
    );
endmodule
`default_nettype wire
